/* src/fss_pkg.sv */
// ----------------------------------------------------------------------------
// Flash save sequencer package
// Shared types and constants of the flash save sequencer: request and result
// records, configuration record, phase and action codes, and sizing constants.
// ----------------------------------------------------------------------------
package fss_pkg;

    // Flash geometry and image limits.
    localparam int PAGE_BYTES = 256;
    localparam int MAX_PAGES  = 16;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int IMG_CAP    = MAX_PAGES * PAGE_BYTES;

    // Field widths.
    localparam int TIME_W    = 32;
    localparam int TMO_W     = 16;
    localparam int FAIL_W    = 8;
    localparam int IMG_W     = 13;
    localparam int ADDR_W    = 24;
    localparam int LEN_W     = 9;
    localparam int PIDX_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    // Sector alignment mask for the base address (4 KiB sectors).
    localparam logic [ADDR_W-1:0] SECTOR_MASK = 24'hFFF000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ERASE_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_TIMEOUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FAILURES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BYTES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS  = 3'd4;

    // Configuration reset values.
    localparam logic [TMO_W-1:0]  RST_ERASE_TIMEOUT = 16'd3000;
    localparam logic [TMO_W-1:0]  RST_PAGE_TIMEOUT  = 16'd1500;
    localparam logic [FAIL_W-1:0] RST_MAX_FAILURES  = 8'd8;
    localparam logic [IMG_W-1:0]  RST_IMAGE_BYTES   = 13'd512;
    localparam logic [ADDR_W-1:0] RST_BASE_ADDRESS  = 24'hFE0000;

    // Request kinds.
    localparam logic KIND_SAVE = 1'b0;
    localparam logic KIND_POLL = 1'b1;

    // Command outcomes; every other code counts as an error.
    localparam logic [1:0] CMD_OK   = 2'd0;
    localparam logic [1:0] CMD_BUSY = 2'd1;

    localparam logic [FAIL_W-1:0] FAIL_SAT = 8'hFF;

    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_ERASE_WAIT = 2'd1,
        PH_PAGE_ISSUE = 2'd2,
        PH_PAGE_WAIT  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_ERASE = 2'd1,
        ACT_PAGE  = 2'd2,
        ACT_POLL  = 2'd3
    } action_t;

    typedef struct packed {
        logic              kind;
        logic [TIME_W-1:0] now_ms;
        logic              other_holds_lock;
        logic [1:0]        cmd_result;
        logic              status_ok;
        logic              wip_bit;
    } req_item_t;

    typedef struct packed {
        action_t           action;
        logic [ADDR_W-1:0] flash_addr;
        logic [LEN_W-1:0]  write_len;
        phase_t            phase;
        logic              save_pending;
        logic              lock_held;
        logic [FAIL_W-1:0] fail_count;
        logic              save_done;
    } res_item_t;

    typedef struct packed {
        logic [TMO_W-1:0]  erase_timeout_ms;
        logic [TMO_W-1:0]  page_timeout_ms;
        logic [FAIL_W-1:0] max_failures;
        logic [IMG_W-1:0]  image_bytes;
        logic [ADDR_W-1:0] base_address;
    } cfg_t;

endpackage

/* src/fss_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Flash save sequencer configuration registers
// Holds the timeouts, failure limit, image size and base address, written
// through a simple write port.
// ----------------------------------------------------------------------------
module fss_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fss_pkg::CFG_DAT_W-1:0]    cfg_wdata,
    output fss_pkg::cfg_t                    cfg
);

    fss_pkg::cfg_t cfg_reg;
    fss_pkg::cfg_t cfg_next;

    // Decode the write into the addressed register; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                fss_pkg::REG_ERASE_TIMEOUT:
                    cfg_next.erase_timeout_ms = cfg_wdata[fss_pkg::TMO_W-1:0];
                fss_pkg::REG_PAGE_TIMEOUT:
                    cfg_next.page_timeout_ms = cfg_wdata[fss_pkg::TMO_W-1:0];
                fss_pkg::REG_MAX_FAILURES:
                    cfg_next.max_failures = cfg_wdata[fss_pkg::FAIL_W-1:0];
                fss_pkg::REG_IMAGE_BYTES:
                    cfg_next.image_bytes = cfg_wdata[fss_pkg::IMG_W-1:0];
                fss_pkg::REG_BASE_ADDRESS:
                    cfg_next.base_address = cfg_wdata[fss_pkg::ADDR_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Register bank with its documented reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.erase_timeout_ms <= fss_pkg::RST_ERASE_TIMEOUT;
            cfg_reg.page_timeout_ms  <= fss_pkg::RST_PAGE_TIMEOUT;
            cfg_reg.max_failures     <= fss_pkg::RST_MAX_FAILURES;
            cfg_reg.image_bytes      <= fss_pkg::RST_IMAGE_BYTES;
            cfg_reg.base_address     <= fss_pkg::RST_BASE_ADDRESS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/fss_core.sv */
// ----------------------------------------------------------------------------
// Flash save sequencer core
// Holds the save state (phase, pending flag, failures, page, start time and
// lock) and computes one request's result and next state in a single step.
// ----------------------------------------------------------------------------
module fss_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  fss_pkg::req_item_t   req,
    input  fss_pkg::cfg_t        cfg,
    output fss_pkg::res_item_t   res
);

    localparam int PCNT_W = fss_pkg::IMG_W + 1 - fss_pkg::PAGE_SHIFT;

    fss_pkg::phase_t                  phase_reg, phase_next;
    logic                             pending_reg, pending_next;
    logic [fss_pkg::FAIL_W-1:0]       fail_reg, fail_next;
    logic [fss_pkg::PIDX_W-1:0]       page_reg, page_next;
    logic [fss_pkg::TIME_W-1:0]       start_reg, start_next;
    logic                             lock_reg, lock_next;

    logic [fss_pkg::IMG_W-1:0]        img_size;
    logic [fss_pkg::IMG_W:0]          img_round;
    logic [PCNT_W-1:0]                page_cnt;
    logic [fss_pkg::IMG_W-1:0]        page_off;
    logic [fss_pkg::IMG_W-1:0]        remain;
    logic                             past_end;
    logic [fss_pkg::LEN_W-1:0]        page_len;
    logic [fss_pkg::ADDR_W-1:0]       sector_base;
    logic [fss_pkg::ADDR_W-1:0]       page_addr;
    logic [fss_pkg::TMO_W-1:0]        limit;
    logic [fss_pkg::TIME_W-1:0]       elapsed;
    logic                             timed_out;
    logic                             wip_clear;
    logic [fss_pkg::PIDX_W-1:0]       page_inc;
    logic                             last_page;
    logic [fss_pkg::FAIL_W-1:0]       fail_inc;
    logic                             fail_drop;
    logic                             issue_free;

    fss_pkg::action_t                 action;
    logic [fss_pkg::ADDR_W-1:0]       addr;
    logic [fss_pkg::LEN_W-1:0]        len;
    logic                             done;

    // Image geometry: clamp the size, round up to pages, locate the current page.
    always_comb
    begin
        img_size  = (cfg.image_bytes > fss_pkg::IMG_W'(fss_pkg::IMG_CAP))
                    ? fss_pkg::IMG_W'(fss_pkg::IMG_CAP) : cfg.image_bytes;
        img_round = {1'b0, img_size} + (fss_pkg::IMG_W + 1)'(fss_pkg::PAGE_BYTES - 1);
        page_cnt  = img_round[fss_pkg::IMG_W:fss_pkg::PAGE_SHIFT];
        page_off  = fss_pkg::IMG_W'({page_reg, {fss_pkg::PAGE_SHIFT{1'b0}}});
        past_end  = (page_off >= img_size);
        remain    = img_size - page_off;
        page_len  = (remain > fss_pkg::IMG_W'(fss_pkg::PAGE_BYTES))
                    ? fss_pkg::LEN_W'(fss_pkg::PAGE_BYTES) : remain[fss_pkg::LEN_W-1:0];
        sector_base = cfg.base_address & fss_pkg::SECTOR_MASK;
        page_addr   = sector_base + fss_pkg::ADDR_W'(page_off);
    end

    // Wait checks, page advance and failure bookkeeping.
    always_comb
    begin
        limit      = (phase_reg == fss_pkg::PH_ERASE_WAIT)
                     ? cfg.erase_timeout_ms : cfg.page_timeout_ms;
        elapsed    = req.now_ms - start_reg;
        timed_out  = (elapsed > fss_pkg::TIME_W'(limit));
        wip_clear  = req.status_ok && !req.wip_bit;
        page_inc   = page_reg + fss_pkg::PIDX_W'(1);
        last_page  = ({1'b0, page_inc} >= PCNT_W'(page_cnt));
        fail_inc   = (fail_reg == fss_pkg::FAIL_SAT) ? fail_reg
                     : fail_reg + fss_pkg::FAIL_W'(1);
        fail_drop  = (fail_inc >= cfg.max_failures);
        issue_free = !req.other_holds_lock && !lock_reg;
    end

    // Next state of the sequencer.
    always_comb
    begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        fail_next    = fail_reg;
        page_next    = page_reg;
        start_next   = start_reg;
        lock_next    = lock_reg;
        if (step_en)
        begin
            if (req.kind == fss_pkg::KIND_SAVE)
            begin
                pending_next = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    fss_pkg::PH_IDLE:
                    begin
                        // Start the erase once nobody holds the lock.
                        if (pending_reg && issue_free)
                        begin
                            if (req.cmd_result == fss_pkg::CMD_OK)
                            begin
                                pending_next = 1'b0;
                                lock_next    = 1'b1;
                                fail_next    = '0;
                                phase_next   = fss_pkg::PH_ERASE_WAIT;
                                page_next    = '0;
                                start_next   = req.now_ms;
                            end
                            else if (req.cmd_result != fss_pkg::CMD_BUSY)
                            begin
                                pending_next = 1'b0;
                            end
                        end
                    end
                    fss_pkg::PH_ERASE_WAIT, fss_pkg::PH_PAGE_WAIT:
                    begin
                        if (timed_out)
                        begin
                            lock_next  = 1'b0;
                            phase_next = fss_pkg::PH_IDLE;
                            fail_next  = fail_inc;
                            if (fail_drop)
                            begin
                                pending_next = 1'b0;
                            end
                        end
                        else if (wip_clear)
                        begin
                            lock_next = 1'b0;
                            if (phase_reg == fss_pkg::PH_ERASE_WAIT)
                            begin
                                phase_next = fss_pkg::PH_PAGE_ISSUE;
                            end
                            else
                            begin
                                page_next = page_inc;
                                if (last_page)
                                begin
                                    phase_next = fss_pkg::PH_IDLE;
                                    fail_next  = '0;
                                end
                                else
                                begin
                                    phase_next = fss_pkg::PH_PAGE_ISSUE;
                                end
                            end
                        end
                    end
                    fss_pkg::PH_PAGE_ISSUE:
                    begin
                        if (issue_free)
                        begin
                            if (!past_end && req.cmd_result == fss_pkg::CMD_OK)
                            begin
                                lock_next  = 1'b1;
                                phase_next = fss_pkg::PH_PAGE_WAIT;
                                start_next = req.now_ms;
                            end
                            else if (past_end || req.cmd_result != fss_pkg::CMD_BUSY)
                            begin
                                lock_next  = 1'b0;
                                phase_next = fss_pkg::PH_IDLE;
                                fail_next  = fail_inc;
                                if (fail_drop)
                                begin
                                    pending_next = 1'b0;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // Command reported for this request.
    always_comb
    begin
        action = fss_pkg::ACT_NONE;
        addr   = '0;
        len    = '0;
        done   = 1'b0;
        if (req.kind == fss_pkg::KIND_POLL)
        begin
            case (phase_reg)
                fss_pkg::PH_IDLE:
                begin
                    if (pending_reg && issue_free)
                    begin
                        action = fss_pkg::ACT_ERASE;
                        addr   = sector_base;
                    end
                end
                fss_pkg::PH_ERASE_WAIT, fss_pkg::PH_PAGE_WAIT:
                begin
                    if (!timed_out)
                    begin
                        action = fss_pkg::ACT_POLL;
                        done   = wip_clear && (phase_reg == fss_pkg::PH_PAGE_WAIT)
                                 && last_page;
                    end
                end
                fss_pkg::PH_PAGE_ISSUE:
                begin
                    if (issue_free && !past_end)
                    begin
                        action = fss_pkg::ACT_PAGE;
                        addr   = page_addr;
                        len    = page_len;
                    end
                end
                default:
                begin
                    action = fss_pkg::ACT_NONE;
                end
            endcase
        end
    end

    // Result record: command plus the state after the step.
    always_comb
    begin
        res.action       = action;
        res.flash_addr   = addr;
        res.write_len    = len;
        res.phase        = phase_next;
        res.save_pending = pending_next;
        res.lock_held    = lock_next;
        res.fail_count   = fail_next;
        res.save_done    = done;
    end

    // Sequencer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= fss_pkg::PH_IDLE;
            pending_reg <= 1'b0;
            fail_reg    <= '0;
            page_reg    <= '0;
            start_reg   <= '0;
            lock_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            fail_reg    <= fail_next;
            page_reg    <= page_next;
            start_reg   <= start_next;
            lock_reg    <= lock_next;
        end
    end

    // The lock is held exactly while a command waits for its WIP bit.
    a_lock_matches_wait: assert property (@(posedge clk) disable iff (!rst_n)
        lock_reg == (phase_reg == fss_pkg::PH_ERASE_WAIT ||
                     phase_reg == fss_pkg::PH_PAGE_WAIT))
        else $error("lock flag disagrees with the wait phase");

    // The page index never runs past the page count of the largest image (one past its last page).
    a_page_bound: assert property (@(posedge clk) disable iff (!rst_n)
        page_reg <= fss_pkg::PIDX_W'(fss_pkg::MAX_PAGES))
        else $error("page index beyond the image area");

    // Without a step the sequencer state holds.
    a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(phase_reg) && $stable(fail_reg) && $stable(pending_reg))
        else $error("sequencer state changed without a request");

    // A completed save returns to idle with the failure count cleared.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && done |=> phase_reg == fss_pkg::PH_IDLE && fail_reg == '0)
        else $error("save completion left the sequencer busy");

endmodule

/* src/flash_save_sequencer.sv */
// ----------------------------------------------------------------------------
// Flash save sequencer
// Takes one request per clock (save request or poll step) unless stalled and
// returns one result per request, in order. A request is registered on
// acceptance, decided against the sequencer state once the result register is
// free or draining, and written to the result register; the result register
// decouples the output, so the input keeps flowing while a result waits to be
// taken and stalls only when both the request and result registers are full
// and the held result is not being taken. Configuration is to be written by
// the user only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module flash_save_sequencer
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  fss_pkg::req_item_t               req_item,
    output logic                             res_valid,
    input  logic                             res_ready,
    output fss_pkg::res_item_t               res_item,
    input  logic                             cfg_we,
    input  logic [fss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fss_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

    fss_pkg::cfg_t       cfg;
    fss_pkg::req_item_t  in_data_reg;
    logic                in_vld_reg, in_vld_next;
    fss_pkg::res_item_t  out_data_reg;
    logic                out_vld_reg, out_vld_next;
    fss_pkg::res_item_t  step_res;
    logic                step_en;
    logic                req_take;

    fss_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fss_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .req     (in_data_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    // Handshake: a held request steps when the result register is free or draining.
    always_comb
    begin
        step_en      = in_vld_reg && (!out_vld_reg || res_ready);
        req_ready    = !in_vld_reg || step_en;
        req_take     = req_valid && req_ready;
        in_vld_next  = req_take || (in_vld_reg && !step_en);
        out_vld_next = step_en || (out_vld_reg && !res_ready);
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            in_data_reg <= req_item;
        end
        if (step_en)
        begin
            out_data_reg <= step_res;
        end
    end

    assign res_valid = out_vld_reg;
    assign res_item  = out_data_reg;

endmodule
